// ===== sv/irf_pkg.sv =====
// shared types and constants for the rotate / flip engine
package irf_pkg;

    localparam int SIZE_W = 9;
    localparam int PIX_IO_W = 24;
    localparam int COORD_W = 8;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register indexes on the config port
    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_WIDTH = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // command field codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [1:0] {
        MODE_ROT_RIGHT = 2'd0,
        MODE_ROT_LEFT  = 2'd1,
        MODE_FLIP_VERT = 2'd2,
        MODE_FLIP_HORZ = 2'd3
    } xform_mode_t;

    // controller to datapath
    typedef struct packed {
        logic load_en;
        logic read_en;
        logic capture;
    } irf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic frame_valid;
        logic out_free;
    } irf_status_t;

endpackage

// ===== sv/irf_ram.sv =====
// generic single-port-write, registered-read ram
module irf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/irf_ctrl.sv =====
// transaction sequencing state machine
module irf_ctrl
    import irf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        command,
    output logic        in_ready,
    input  irf_status_t status,
    output irf_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE    = 2'b01,
        ST_RD_WAIT = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && command == CMD_LOAD)
                begin
                    cmd.load_en = 1'b1;
                end
                // reads before a full frame are dropped silently
                if (accept && command == CMD_READ && status.frame_valid)
                begin
                    cmd.read_en = 1'b1;
                    state_next = ST_RD_WAIT;
                end
            end
            ST_RD_WAIT:
            begin
                if (status.out_free)
                begin
                    cmd.capture = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/irf_datapath.sv =====
// counters, address generation, frame memory and output register
module irf_datapath
    import irf_pkg::*;
#(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int PIXEL_BITS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  irf_cmd_t            cmd,
    output irf_status_t         status,
    input  xform_mode_t         mode,
    input  logic [SIZE_W-1:0]   img_w,
    input  logic [SIZE_W-1:0]   img_h,
    input  logic                mode_wr,
    input  logic                size_wr,
    input  logic [PIX_IO_W-1:0] pixel_in,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [PIX_IO_W-1:0] pixel_out,
    output logic [COORD_W-1:0]  out_row,
    output logic [COORD_W-1:0]  out_col,
    output logic                last_pixel
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int EW = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int MW = (EW > SIZE_W) ? EW : SIZE_W;

    logic [ROW_W-1:0] load_row_reg, load_row_next;
    logic [COL_W-1:0] load_col_reg, load_col_next;
    logic [EW-1:0]    emit_row_reg, emit_row_next;
    logic [EW-1:0]    emit_col_reg, emit_col_next;
    logic             frame_valid_reg, frame_valid_next;
    logic             out_valid_reg, out_valid_next;

    logic [MW-1:0] w_m1, h_m1, ow_m1, oh_m1;
    logic [MW-1:0] orow, ocol, src_row, src_col;
    logic          load_col_end, load_row_end;
    logic          emit_col_end, emit_row_end;
    logic          rot;

    logic [ADDR_W-1:0]     wr_addr, rd_addr;
    logic [PIXEL_BITS-1:0] rd_data;

    // pending coordinates while the memory read is in flight
    logic [COORD_W-1:0]  pend_row_reg, pend_col_reg;
    logic                pend_last_reg;
    logic [PIX_IO_W-1:0] pixel_out_reg;
    logic [COORD_W-1:0]  out_row_reg, out_col_reg;
    logic                last_pixel_reg;

    assign rot = (mode == MODE_ROT_RIGHT) || (mode == MODE_ROT_LEFT);
    assign w_m1 = MW'(img_w) - MW'(1);
    assign h_m1 = MW'(img_h) - MW'(1);
    assign ow_m1 = rot ? h_m1 : w_m1;
    assign oh_m1 = rot ? w_m1 : h_m1;
    assign orow = MW'(emit_row_reg);
    assign ocol = MW'(emit_col_reg);

    assign load_col_end = (MW'(load_col_reg) == w_m1);
    assign load_row_end = (MW'(load_row_reg) == h_m1);
    assign emit_col_end = (ocol == ow_m1);
    assign emit_row_end = (orow == oh_m1);

    always_comb
    begin
        case (mode)
            MODE_ROT_RIGHT:
            begin
                src_row = h_m1 - ocol;
                src_col = orow;
            end
            MODE_ROT_LEFT:
            begin
                src_row = ocol;
                src_col = w_m1 - orow;
            end
            MODE_FLIP_VERT:
            begin
                src_row = h_m1 - orow;
                src_col = ocol;
            end
            default:
            begin
                src_row = orow;
                src_col = w_m1 - ocol;
            end
        endcase
    end

    assign wr_addr = ADDR_W'(load_row_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(load_col_reg);
    assign rd_addr = ADDR_W'(src_row[ROW_W-1:0]) * ADDR_W'(MAX_WIDTH)
                   + ADDR_W'(src_col[COL_W-1:0]);

    irf_ram #(
        .WIDTH(PIXEL_BITS),
        .DEPTH(DEPTH)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (cmd.load_en),
        .wr_addr (wr_addr),
        .wr_data (PIXEL_BITS'(pixel_in)),
        .rd_en   (cmd.read_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        load_row_next = load_row_reg;
        load_col_next = load_col_reg;
        emit_row_next = emit_row_reg;
        emit_col_next = emit_col_reg;
        frame_valid_next = frame_valid_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.capture)
        begin
            out_valid_next = 1'b1;
        end

        if (cmd.load_en)
        begin
            if (load_col_end)
            begin
                load_col_next = '0;
                if (load_row_end)
                begin
                    load_row_next = '0;
                    frame_valid_next = 1'b1;
                end
                else
                begin
                    load_row_next = load_row_reg + 1'b1;
                end
            end
            else
            begin
                load_col_next = load_col_reg + 1'b1;
            end
        end

        if (cmd.read_en)
        begin
            if (emit_col_end)
            begin
                emit_col_next = '0;
                emit_row_next = emit_row_end ? '0 : emit_row_reg + 1'b1;
            end
            else
            begin
                emit_col_next = emit_col_reg + 1'b1;
            end
        end

        if (mode_wr)
        begin
            emit_row_next = '0;
            emit_col_next = '0;
        end
        if (size_wr)
        begin
            load_row_next = '0;
            load_col_next = '0;
            emit_row_next = '0;
            emit_col_next = '0;
            frame_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_row_reg <= '0;
            load_col_reg <= '0;
            emit_row_reg <= '0;
            emit_col_reg <= '0;
            frame_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            load_row_reg <= load_row_next;
            load_col_reg <= load_col_next;
            emit_row_reg <= emit_row_next;
            emit_col_reg <= emit_col_next;
            frame_valid_reg <= frame_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_en)
        begin
            pend_row_reg <= COORD_W'(emit_row_reg);
            pend_col_reg <= COORD_W'(emit_col_reg);
            pend_last_reg <= emit_col_end && emit_row_end;
        end
        if (cmd.capture)
        begin
            pixel_out_reg <= PIX_IO_W'(rd_data);
            out_row_reg <= pend_row_reg;
            out_col_reg <= pend_col_reg;
            last_pixel_reg <= pend_last_reg;
        end
    end

    assign status.frame_valid = frame_valid_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign out_row = out_row_reg;
    assign out_col = out_col_reg;
    assign last_pixel = last_pixel_reg;

endmodule

// ===== sv/image_rotate_flip_engine.sv =====
// top level of the frame rotate / mirror engine with its register port
// A frame is loaded pixel by pixel in raster order with command 0 and kept in a
// frame memory of MAX_WIDTH * MAX_HEIGHT words; command 1 then returns the next
// pixel of the transformed frame (rotate right, rotate left, vertical flip or
// horizontal flip) in raster order of that frame, with its row, column and a
// last-pixel flag. A read transaction issues the address to the frame memory,
// which has a registered read port; the input is then held off while the
// controller waits for the output register to be free and captures the pixel
// into it. A read issued before a whole frame has been loaded is accepted and
// gives no result. The output register lets the next transaction be accepted
// while a result still waits downstream. The memory holds no reset contents and
// needs no clearing pass. Writing image_width or image_height restarts loading
// and invalidates the frame; writing transform_mode restarts read-out only.
// Register map: 0x0 transform_mode, 0x4 image_width, 0x8 image_height. A size
// write keeps its low nine bits; 0 reads back as 1 and larger values saturate.
module image_rotate_flip_engine
    import irf_pkg::*;
#(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int PIXEL_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // config port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // input channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  command,
    input  logic [PIX_IO_W-1:0]   pixel_in,
    // output channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_IO_W-1:0]   pixel_out,
    output logic [COORD_W-1:0]    out_row,
    output logic [COORD_W-1:0]    out_col,
    output logic                  last_pixel
);

    // reset sizes are the maximum, capped at 256
    localparam logic [SIZE_W-1:0] WIDTH_RST = SIZE_W'((MAX_WIDTH < 256) ? MAX_WIDTH : 256);
    localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'((MAX_HEIGHT < 256) ? MAX_HEIGHT : 256);

    xform_mode_t       mode_reg, mode_next;
    logic [SIZE_W-1:0] width_reg, width_next;
    logic [SIZE_W-1:0] height_reg, height_next;

    logic              wr_strobe;
    logic [1:0]        reg_idx;
    logic [SIZE_W-1:0] wdata_size;
    logic [SIZE_W-1:0] width_clamped, height_clamped;
    logic              mode_wr, size_wr;

    irf_cmd_t    cmd;
    irf_status_t status;

    assign pready = 1'b1;
    assign wr_strobe = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign wdata_size = pwdata[SIZE_W-1:0];

    // zero maps to one, anything past the maximum saturates
    always_comb
    begin
        if (wdata_size == '0)
        begin
            width_clamped = SIZE_W'(1);
        end
        else if (32'(wdata_size) > MAX_WIDTH)
        begin
            width_clamped = SIZE_W'(MAX_WIDTH);
        end
        else
        begin
            width_clamped = wdata_size;
        end

        if (wdata_size == '0)
        begin
            height_clamped = SIZE_W'(1);
        end
        else if (32'(wdata_size) > MAX_HEIGHT)
        begin
            height_clamped = SIZE_W'(MAX_HEIGHT);
        end
        else
        begin
            height_clamped = wdata_size;
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        width_next = width_reg;
        height_next = height_reg;
        mode_wr = 1'b0;
        size_wr = 1'b0;
        if (wr_strobe)
        begin
            case (reg_idx)
                REG_MODE:
                begin
                    mode_next = xform_mode_t'(pwdata[1:0]);
                    mode_wr = 1'b1;
                end
                REG_WIDTH:
                begin
                    width_next = width_clamped;
                    size_wr = 1'b1;
                end
                REG_HEIGHT:
                begin
                    height_next = height_clamped;
                    size_wr = 1'b1;
                end
                default:
                begin
                    // unmapped address, write dropped
                    mode_wr = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ROT_RIGHT;
            width_reg <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else
        begin
            mode_reg <= mode_next;
            width_reg <= width_next;
            height_reg <= height_next;
        end
    end

    // register read-back
    always_comb
    begin
        case (reg_idx)
            REG_MODE:   prdata = APB_DATA_W'(mode_reg);
            REG_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // sequencing of load / read transactions
    irf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // counters, address math, frame memory, output register
    irf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .mode       (mode_reg),
        .img_w      (width_reg),
        .img_h      (height_reg),
        .mode_wr    (mode_wr),
        .size_wr    (size_wr),
        .pixel_in   (pixel_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_out  (pixel_out),
        .out_row    (out_row),
        .out_col    (out_col),
        .last_pixel (last_pixel)
    );

endmodule
